[rtl/tlpt_pkg.sv]
package tlpt_pkg;

   // request codes
   localparam logic [1:0] REQ_OPEN      = 2'd0;
   localparam logic [1:0] REQ_ALLOC     = 2'd1;
   localparam logic [1:0] REQ_TRANSLATE = 2'd2;
   localparam logic [1:0] REQ_RELEASE   = 2'd3;

   // response status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_SLOT    = 3'd1;
   localparam logic [2:0] ST_INACTIVE   = 3'd2;
   localparam logic [2:0] ST_LIMIT      = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_BAD_OFFSET = 3'd5;
   localparam logic [2:0] ST_NOT_MAPPED = 3'd6;

   // field widths
   localparam int REQ_W    = 2;
   localparam int SLOT_F_W = 2;
   localparam int PHYS_W   = 20;
   localparam int VA_W     = 32;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 32;
   localparam int LIMIT_W  = 11;

   // virtual address layout
   localparam int IDX_W      = 10;
   localparam int DIR_SHIFT  = 22;
   localparam int PAGE_SHIFT = 12;
   localparam int OFFSET_W   = 12;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd64;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // run checks, touch the page store, update slot state
   } cmd_type;

endpackage

[rtl/tlpt_req_if.sv]
interface tlpt_req_if;
   import tlpt_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [SLOT_F_W-1:0] slot;
   logic [PHYS_W-1:0]   phys_page;
   logic [VA_W-1:0]     virt_addr;

   modport source (output valid, output req_type, output slot, output phys_page,
                   output virt_addr, input ready);
   modport sink   (input valid, input req_type, input slot, input phys_page,
                   input virt_addr, output ready);
endinterface

[rtl/tlpt_rsp_if.sv]
interface tlpt_rsp_if;
   import tlpt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink   (input valid, input status, input result_value, output ready);
endinterface

[rtl/two_level_page_table_engine_top.sv]
// Two-level page table engine: per-context page tables for up to SLOTS contexts.
// Request channel (req_chan): req_type selects open, allocate, translate or
//   release; slot, phys_page and virt_addr carry the operands. A request is
//   taken on a clock edge with valid and ready both high.
// Response channel (rsp_chan): one response per request, status plus
//   result_value (slot index, new virtual address or physical page; zero on
//   any error), held stable until the receiver takes it.
// csr_wr_en/csr_wr_data write the per-context allocation limit; only write
//   while no request is in flight.
// Timing: one request at a time. Between acceptance and response lie the
//   request register, the registered read port of the page store and the
//   response register; no new request is taken until the response is taken.
// Reset (synchronous, active high): all contexts inactive, fill counts zero,
//   limit back to 64. Page store contents are left as they are; only entries
//   below a context's fill count are ever returned.
// Receiver stall: the response waits in its register and req ready stays low
//   until it is taken.
module two_level_page_table_engine_top
   import tlpt_pkg::*;
#(
   parameter int SLOTS        = 4,
   parameter int DIR_ENTRIES  = 16,
   parameter int PAGE_ENTRIES = 64
)
(
   input  logic               clock,
   input  logic               reset,
   tlpt_req_if.sink           req_chan,
   tlpt_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   cmd_type cmd;

   // sequencer: idle -> execute -> respond
   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // checks, slot state, page store and response register
   tlpt_dp #(
      .SLOTS        (SLOTS),
      .DIR_ENTRIES  (DIR_ENTRIES),
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_chan.req_type),
      .req_slot         (req_chan.slot),
      .req_phys_page    (req_chan.phys_page),
      .req_virt_addr    (req_chan.virt_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_status       (rsp_chan.status),
      .rsp_result_value (rsp_chan.result_value)
   );

   // never take a new request while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_chan.valid && req_chan.ready))
      else $error("request taken while response pending");

   // response becomes valid after acceptance, once the execute state has run
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> ##1 rsp_chan.valid)
      else $error("response not valid two cycles after request");

   // error responses carry zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |-> (rsp_chan.result_value == '0))
      else $error("non-zero value on error response");

   // a successful open returns an existing slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_OK) && $past(req_chan.valid, 2)
       && $past(req_chan.ready, 2) && ($past(req_chan.req_type, 2) == REQ_OPEN))
      |-> (rsp_chan.result_value < SLOTS))
      else $error("open returned slot beyond range");

endmodule

[rtl/tlpt_ctrl.sv]
module tlpt_ctrl
   import tlpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/tlpt_dp.sv]
module tlpt_dp
   import tlpt_pkg::*;
#(
   parameter int SLOTS        = 4,
   parameter int DIR_ENTRIES  = 16,
   parameter int PAGE_ENTRIES = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [SLOT_F_W-1:0] req_slot,
   input  logic [PHYS_W-1:0]   req_phys_page,
   input  logic [VA_W-1:0]     req_virt_addr,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_result_value
);

   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DIR_W        = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int PAGE_W       = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
   localparam int ND_W         = $clog2(DIR_ENTRIES + 1);
   localparam int ADDR_W       = SLOT_W + DIR_W + PAGE_W;
   localparam int MEM_DEPTH    = 2 ** ADDR_W;
   localparam int SLOT_ENTRIES = DIR_ENTRIES * PAGE_ENTRIES;

   // latched request
   logic [REQ_W-1:0]    type_ff;
   logic [SLOT_F_W-1:0] slot_ff;
   logic [PHYS_W-1:0]   phys_ff;
   logic [VA_W-1:0]     va_ff;

   logic [LIMIT_W-1:0]  limit_ff;

   // per-slot state; next dir/page mirror the fill count
   logic               active_ff [SLOTS];
   logic [LIMIT_W-1:0] fill_ff   [SLOTS];
   logic [ND_W-1:0]    nd_ff     [SLOTS];
   logic [PAGE_W-1:0]  np_ff     [SLOTS];
   logic               active_in [SLOTS];
   logic [LIMIT_W-1:0] fill_in   [SLOTS];
   logic [ND_W-1:0]    nd_in     [SLOTS];
   logic [PAGE_W-1:0]  np_in     [SLOTS];

   logic [PHYS_W-1:0]  mem [MEM_DEPTH];
   logic [PHYS_W-1:0]  rdata_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                use_mem_ff, use_mem_in;

   logic [SLOT_W+SLOT_F_W-1:0] slot_ext;
   logic [SLOT_W-1:0]  slot_idx;
   logic               slot_in_range;
   logic               sel_active;
   logic [LIMIT_W-1:0] sel_fill;
   logic [ND_W-1:0]    sel_nd;
   logic [PAGE_W-1:0]  sel_np;
   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;
   logic [IDX_W-1:0]   va_dir, va_page;
   logic               mapped;
   logic               mem_wr;
   logic [ADDR_W-1:0]  mem_addr;

   assign slot_ext      = {{SLOT_W{1'b0}}, slot_ff};
   assign slot_idx      = slot_ext[SLOT_W-1:0];
   assign slot_in_range = (32'(slot_ff) < SLOTS);
   assign va_dir        = va_ff[DIR_SHIFT +: IDX_W];
   assign va_page       = va_ff[PAGE_SHIFT +: IDX_W];

   // slot lookup and lowest free slot
   always_comb begin
      sel_active = 1'b0;
      sel_fill   = '0;
      sel_nd     = '0;
      sel_np     = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_in_range && (slot_idx == SLOT_W'(i))) begin
            sel_active = active_ff[i];
            sel_fill   = fill_ff[i];
            sel_nd     = nd_ff[i];
            sel_np     = np_ff[i];
         end
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // entry (dir, page) lies below the fill count
   assign mapped = (11'(va_dir) < 11'(sel_nd)) ||
                   ((11'(va_dir) == 11'(sel_nd)) && (11'(va_page) < 11'(sel_np)));

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         active_in[i] = active_ff[i];
         fill_in[i]   = fill_ff[i];
         nd_in[i]     = nd_ff[i];
         np_in[i]     = np_ff[i];
      end
      status_in  = ST_OK;
      value_in   = '0;
      use_mem_in = 1'b0;
      mem_wr     = 1'b0;
      mem_addr   = {slot_idx, va_dir[DIR_W-1:0], va_page[PAGE_W-1:0]};

      if (type_ff == REQ_OPEN) begin
         if (free_found) begin
            value_in = VALUE_W'(free_idx);
            for (int i = 0; i < SLOTS; i++) begin
               if (free_idx == SLOT_W'(i)) begin
                  active_in[i] = 1'b1;
                  fill_in[i]   = '0;
                  nd_in[i]     = '0;
                  np_in[i]     = '0;
               end
            end
         end else begin
            status_in = ST_NO_SLOT;
         end
      end else if (!sel_active) begin
         status_in = ST_INACTIVE;
      end else begin
         unique case (type_ff)
            REQ_ALLOC: begin
               mem_addr = {slot_idx, sel_nd[DIR_W-1:0], sel_np};
               if (sel_fill >= limit_ff) begin
                  status_in = ST_LIMIT;
               end else if (32'(sel_fill) >= SLOT_ENTRIES) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr   = 1'b1;
                  value_in = {IDX_W'(sel_nd), IDX_W'(sel_np), {OFFSET_W{1'b0}}};
                  for (int i = 0; i < SLOTS; i++) begin
                     if (slot_idx == SLOT_W'(i)) begin
                        fill_in[i] = sel_fill + 1'b1;
                        if (32'(sel_np) == PAGE_ENTRIES - 1) begin
                           np_in[i] = '0;
                           nd_in[i] = sel_nd + 1'b1;
                        end else begin
                           np_in[i] = sel_np + 1'b1;
                        end
                     end
                  end
               end
            end
            REQ_TRANSLATE: begin
               if (va_ff[OFFSET_W-1:0] != '0) begin
                  status_in = ST_BAD_OFFSET;
               end else if ((32'(va_dir) >= DIR_ENTRIES) ||
                            (32'(va_page) >= PAGE_ENTRIES) || !mapped) begin
                  status_in = ST_NOT_MAPPED;
               end else begin
                  use_mem_in = 1'b1;
               end
            end
            REQ_RELEASE: begin
               value_in = VALUE_W'(slot_ff);
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_idx == SLOT_W'(i)) begin
                     active_in[i] = 1'b0;
                     fill_in[i]   = '0;
                     nd_in[i]     = '0;
                     np_in[i]     = '0;
                  end
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         slot_ff <= req_slot;
         phys_ff <= req_phys_page;
         va_ff   <= req_virt_addr;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         use_mem_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            active_ff[i] <= 1'b0;
            fill_ff[i]   <= '0;
            nd_ff[i]     <= '0;
            np_ff[i]     <= '0;
         end
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (cmd.execute) begin
            use_mem_ff <= use_mem_in;
            for (int i = 0; i < SLOTS; i++) begin
               active_ff[i] <= active_in[i];
               fill_ff[i]   <= fill_in[i];
               nd_ff[i]     <= nd_in[i];
               np_ff[i]     <= np_in[i];
            end
         end
      end
   end

   // page store: one port, registered read
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (mem_wr) mem[mem_addr] <= phys_ff;
         rdata_ff <= mem[mem_addr];
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_value = use_mem_ff ? VALUE_W'(rdata_ff) : value_ff;

endmodule

[tb/sv/two_level_page_table_engine_checker.sv]
module two_level_page_table_engine_checker
   import tlpt_pkg::*;
#(
   parameter int SLOTS        = 4,
   parameter int DIR_ENTRIES  = 16,
   parameter int PAGE_ENTRIES = 64
)
(
   input  logic               clock,
   input  logic               reset,
   tlpt_req_if                req_mon,
   tlpt_rsp_if                rsp_mon,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = DIR_ENTRIES * PAGE_ENTRIES;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } tlpt_answer_type;

   logic [LIMIT_W-1:0] limit_reg;
   bit                 slot_live [SLOTS];
   logic [LIMIT_W-1:0] slot_fill [SLOTS];
   logic [PHYS_W-1:0]  frame_store [SLOTS * TABLE_ENTRIES];
   tlpt_answer_type    awaited_answers [$];
   tlpt_answer_type    oldest;
   int                 errors = 0;

   // one request in, one answer out; slot state is updated in place
   function automatic tlpt_answer_type serve_request(input logic [REQ_W-1:0]    kind,
                                                     input logic [SLOT_F_W-1:0] s,
                                                     input logic [PHYS_W-1:0]   phys,
                                                     input logic [VA_W-1:0]     va);
      tlpt_answer_type ans;
      int unsigned     k;
      int unsigned     dir;
      int unsigned     pg;
      bit              found;
      ans.status = ST_OK;
      ans.value  = '0;
      found      = 1'b0;
      if (kind == REQ_OPEN) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!found && !slot_live[i]) begin
               slot_live[i] = 1'b1;
               slot_fill[i] = '0;
               ans.value    = VALUE_W'(i);
               found        = 1'b1;
            end
         end
         if (!found) ans.status = ST_NO_SLOT;
      end else if (int'(s) >= SLOTS || !slot_live[s]) begin
         ans.status = ST_INACTIVE;
      end else begin
         case (kind)
            REQ_ALLOC: begin
               k = slot_fill[s];
               if (k >= limit_reg) begin
                  ans.status = ST_LIMIT;
               end else if (k >= TABLE_ENTRIES) begin
                  ans.status = ST_FULL;
               end else begin
                  frame_store[int'(s) * TABLE_ENTRIES + k] = phys;
                  slot_fill[s] = LIMIT_W'(k + 1);
                  dir = k / PAGE_ENTRIES;
                  pg  = k % PAGE_ENTRIES;
                  ans.value = ((dir & 32'd1023) << DIR_SHIFT) | ((pg & 32'd1023) << PAGE_SHIFT);
               end
            end
            REQ_TRANSLATE: begin
               dir = va[31:DIR_SHIFT];
               pg  = va[DIR_SHIFT-1:PAGE_SHIFT];
               k   = dir * PAGE_ENTRIES + pg;
               if (va[OFFSET_W-1:0] != '0) begin
                  ans.status = ST_BAD_OFFSET;
               end else if (dir >= DIR_ENTRIES || pg >= PAGE_ENTRIES || k >= slot_fill[s]) begin
                  ans.status = ST_NOT_MAPPED;
               end else begin
                  ans.value = VALUE_W'(frame_store[int'(s) * TABLE_ENTRIES + k]);
               end
            end
            default: begin
               slot_live[s] = 1'b0;
               slot_fill[s] = '0;
               ans.value    = VALUE_W'(s);
            end
         endcase
      end
      if (ans.status != ST_OK) ans.value = '0;
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limit_reg = LIMIT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_fill[i] = '0;
         end
         awaited_answers.delete();
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            awaited_answers.push_back(serve_request(req_mon.req_type, req_mon.slot,
                                                    req_mon.phys_page, req_mon.virt_addr));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_answers.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, status %0d value 0x%08h",
                        $time, rsp_mon.status, rsp_mon.result_value);
            end else begin
               oldest = awaited_answers.pop_front();
               if (rsp_mon.status !== oldest.status) begin
                  errors++;
                  $display("%0t: status expected %0d got %0d",
                           $time, oldest.status, rsp_mon.status);
               end
               if (rsp_mon.result_value !== oldest.value) begin
                  errors++;
                  $display("%0t: result_value expected 0x%08h got 0x%08h",
                           $time, oldest.value, rsp_mon.result_value);
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= awaited_answers.size();
   end

endmodule

[tb/sv/two_level_page_table_engine_top_tb.sv]
module two_level_page_table_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tlpt_pkg::*;

   localparam int SLOTS         = 4;
   localparam int DIR_ENTRIES   = 16;
   localparam int PAGE_ENTRIES  = 64;
   localparam int TABLE_ENTRIES = DIR_ENTRIES * PAGE_ENTRIES;

   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 16;    // the table fill makes up most of ~1200 requests
   localparam int DRAIN_CYCLES   = 12;    // room for a stray response after settle
   // worst case per request (gap, engine, receiver stall)
   // over ~1200 requests, then taken many times over
   localparam int CYCLE_LIMIT    = 400000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   tlpt_req_if req_if ();
   tlpt_rsp_if rsp_if ();

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   bit          req_steady;     // sender runs back to back
   bit          rsp_steady;     // receiver never stalls

   two_level_page_table_engine_top #(
      .SLOTS        (SLOTS),
      .DIR_ENTRIES  (DIR_ENTRIES),
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicts and compares every response; the top only drives and judges
   two_level_page_table_engine_checker #(
      .SLOTS        (SLOTS),
      .DIR_ENTRIES  (DIR_ENTRIES),
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) page_table_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_level_page_table_engine_top verification failed");
         $finish;
      end
   end

   // virtual address of entry k of a context: directory k/PAGE_ENTRIES, page k%PAGE_ENTRIES
   function automatic logic [VA_W-1:0] entry_addr(input int unsigned k);
      int unsigned dir;
      int unsigned pg;
      dir = k / PAGE_ENTRIES;
      pg  = k % PAGE_ENTRIES;
      return VA_W'((dir << DIR_SHIFT) | (pg << PAGE_SHIFT));
   endfunction

   // Offer one request after a random gap; returns at the edge that takes it.
   // Valid stays high across back-to-back requests, so it is only lowered
   // when a gap is actually drawn.
   task automatic send_request(input logic [REQ_W-1:0]    kind,
                               input logic [SLOT_F_W-1:0] s,
                               input logic [PHYS_W-1:0]   phys,
                               input logic [VA_W-1:0]     va);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.slot      <= s;
      req_if.phys_page <= phys;
      req_if.virt_addr <= va;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // hold the sender off until every outstanding response is back
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // limit register is only touched while the engine is idle
   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: random stall before each response, none in steady stretches.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // Stimulus
   initial begin
      logic [LIMIT_W-1:0] phase_limits [PHASES];
      int unsigned        pick;
      int unsigned        k;

      phase_limits = '{11'd1, 11'd64, 11'd1024, 11'd0, 11'd3, 11'd2047, 11'd0, 11'd200};
      phase_limits[6] = LIMIT_W'($urandom_range(0, 2047));

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_OPEN;
      req_if.slot      <= '0;
      req_if.phys_page <= '0;
      req_if.virt_addr <= '0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed: everything inactive straight out of reset
      send_request(REQ_TRANSLATE, 2'd0, '0, '0);
      send_request(REQ_ALLOC,     2'd0, '1, '0);
      send_request(REQ_RELEASE,   2'd1, '0, '1);

      // open all four contexts, then one too many
      repeat (SLOTS + 1) send_request(REQ_OPEN, 2'd3, '0, '0);

      // smallest and largest physical page, then read them back
      send_request(REQ_ALLOC, 2'd0, '0, '0);
      send_request(REQ_ALLOC, 2'd0, '1, '1);
      send_request(REQ_TRANSLATE, 2'd0, '0, entry_addr(0));
      send_request(REQ_TRANSLATE, 2'd0, '1, entry_addr(1));
      // entry not filled yet
      send_request(REQ_TRANSLATE, 2'd0, '0, entry_addr(2));
      // offset bits set: offset is checked ahead of the index range
      send_request(REQ_TRANSLATE, 2'd0, '0, 32'h0000_0001);
      send_request(REQ_TRANSLATE, 2'd0, '0, '1);
      // directory and page index beyond the table
      send_request(REQ_TRANSLATE, 2'd0, '0, 32'hFFFF_F000);
      send_request(REQ_TRANSLATE, 2'd0, '0, 32'h0007_F000);

      // release frees the slot, open reclaims the lowest free one
      send_request(REQ_RELEASE, 2'd3, '0, '0);
      send_request(REQ_OPEN,    2'd0, '0, '0);

      // zero limit: nothing may be allocated
      set_limit(11'd0);
      send_request(REQ_ALLOC, 2'd0, '1, '0);
      // limit of two, slot 0 already holds two
      set_limit(11'd2);
      send_request(REQ_ALLOC, 2'd0, '1, '0);

      // fill context 1 completely with the limit out of the way
      send_request(REQ_RELEASE, 2'd1, '0, '0);
      send_request(REQ_OPEN,    2'd0, '0, '0);
      set_limit(11'd2047);
      req_steady = 1'b1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (i == TABLE_ENTRIES / 2) req_steady = 1'b0;
         if (i == TABLE_ENTRIES / 4) rsp_steady = 1'b1;
         if (i == TABLE_ENTRIES * 3 / 4) rsp_steady = 1'b0;
         send_request(REQ_ALLOC, 2'd1, PHYS_W'($urandom), '0);
      end
      // table full, last entry still mapped, one past it is not
      send_request(REQ_ALLOC,     2'd1, '1, '0);
      send_request(REQ_TRANSLATE, 2'd1, '0, entry_addr(TABLE_ENTRIES - 1));
      send_request(REQ_TRANSLATE, 2'd1, '0, entry_addr(TABLE_ENTRIES));
      // at the largest meaningful limit, the limit check wins over table full
      set_limit(11'd1024);
      send_request(REQ_ALLOC, 2'd1, '1, '0);
      send_request(REQ_RELEASE, 2'd1, '0, '0);

      // --- random phases, each under its own limit and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         set_limit(phase_limits[p]);
         req_steady = (p % 3 == 1);
         rsp_steady = (p % 4 == 2);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               send_request(REQ_OPEN, SLOT_F_W'($urandom), PHYS_W'($urandom), VA_W'($urandom));
            end else if (pick < 11) begin
               send_request(REQ_RELEASE, SLOT_F_W'($urandom), '0, '0);
            end else if (pick < 50) begin
               send_request(REQ_ALLOC, SLOT_F_W'($urandom), PHYS_W'($urandom), '0);
            end else if (pick < 85) begin
               // mostly entries near the start of a context, now and then anywhere
               k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TABLE_ENTRIES + 63)
                                               : $urandom_range(0, 95);
               send_request(REQ_TRANSLATE, SLOT_F_W'($urandom), '0, entry_addr(k));
            end else begin
               // noise: any field value at all
               send_request(REQ_W'($urandom), SLOT_F_W'($urandom), PHYS_W'($urandom),
                            VA_W'($urandom));
            end
         end
      end

      // drain, then leave room for any stray response
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("two_level_page_table_engine_top verification clean");
      end else begin
         $display("two_level_page_table_engine_top verification failed");
      end
      $finish;
   end

endmodule
